// File: rtl/chb_pkg.sv
// Package for the cell histogram binner: field widths, the layout of one
// stored cell word, configuration register indexes and the read-out request.
// No dependencies; chb_readout and cell_histogram_binner import it.
package chb_pkg;

  localparam int CELL_W   = 16;
  localparam int VALUE_W  = 32;
  localparam int CLASS_W  = 3;
  localparam int COUNT_W  = 24;
  localparam int TOTAL_W  = 48;
  localparam int MEAN_W   = 32;
  localparam int PRES_W   = 8;
  localparam int NPRES_W  = 4;

  // Input tdata: cell_req, value, class_id from bit 0 up, padded to bytes.
  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 1;
  // Output tdata: cell_out, count, total, mean, presence, classes_present.
  localparam int OUT_DATA_W = 136;

  // One stored cell word: {presence, total, count}.
  localparam int WORD_W   = PRES_W + TOTAL_W + COUNT_W;
  localparam int CNT_LSB  = 0;
  localparam int TOT_LSB  = COUNT_W;
  localparam int PRES_LSB = COUNT_W + TOTAL_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};
  localparam logic [MEAN_W-1:0]  MEAN_MAX  = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic [MEAN_W-1:0]  MEAN_MIN  = {1'b1, {(MEAN_W-1){1'b0}}};

  // Input action codes.
  localparam logic ACT_BIN  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_EMIT_ALL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_VALS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_PRS = 2'd2;

  // Divider steps: one quotient bit per cycle over the whole total.
  localparam int DIV_STEPS  = TOTAL_W;
  localparam int DIV_STEP_W = 6;

  typedef struct packed {
    logic [CELL_W-1:0]         cell_idx;
    logic [COUNT_W-1:0]        count;
    logic signed [TOTAL_W-1:0] total;
    logic [PRES_W-1:0]         presence;
  } rd_req_t;

  typedef enum logic [2:0] {
    RD_IDLE = 3'b001,
    RD_DIV  = 3'b010,
    RD_DONE = 3'b100
  } rd_state_t;

endpackage

// File: rtl/chb_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data (read-before-write on the same address).
// No dependencies.
module chb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/chb_readout.sv
// Read-out unit: takes one cell snapshot, divides the total by the count one
// quotient bit per cycle, saturates the mean and holds the result register.
// Depends on chb_pkg.
module chb_readout (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             req_valid,
  input  chb_pkg::rd_req_t                 req,
  output logic                             busy,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [chb_pkg::OUT_DATA_W-1:0]   out_tdata
);

  import chb_pkg::*;

  rd_state_t               state_r, state_nxt;
  logic [CELL_W-1:0]       cell_r;
  logic [COUNT_W-1:0]      cnt_r;
  logic [TOTAL_W-1:0]      tot_r;
  logic [PRES_W-1:0]       pres_r;
  logic                    neg_r;
  logic [TOTAL_W-1:0]      quo_r, quo_nxt;
  logic [COUNT_W:0]        rem_r, rem_nxt;
  logic [DIV_STEP_W-1:0]   step_r, step_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r;

  logic [COUNT_W:0]        rem_sh;
  logic                    rem_ge;
  logic [MEAN_W-1:0]       mean;
  logic [NPRES_W-1:0]      npres;
  logic                    load_out;

  assign busy       = (state_r != RD_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign rem_sh = {rem_r[COUNT_W-1:0], quo_r[TOTAL_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, cnt_r});
  assign load_out = (state_r == RD_DONE) && (!out_valid_r || out_tready);

  // Truncation toward zero: divide magnitudes, then restore the sign.
  always_comb begin
    if (neg_r) begin
      if (quo_r > TOTAL_W'({1'b1, {(MEAN_W-1){1'b0}}})) begin
        mean = MEAN_MIN;
      end else begin
        mean = MEAN_W'(-quo_r[MEAN_W-1:0]);
      end
    end else begin
      if (quo_r > TOTAL_W'(MEAN_MAX)) begin
        mean = MEAN_MAX;
      end else begin
        mean = quo_r[MEAN_W-1:0];
      end
    end
  end

  always_comb begin
    npres = '0;
    for (int i = 0; i < PRES_W; i++) begin
      npres = npres + NPRES_W'(pres_r[i]);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      RD_IDLE: begin
        if (req_valid) begin
          quo_nxt  = req.total[TOTAL_W-1] ? TOTAL_W'(-req.total) : req.total;
          rem_nxt  = '0;
          step_nxt = '0;
          if (req.count == '0) begin
            quo_nxt   = '0;
            state_nxt = RD_DONE;
          end else begin
            state_nxt = RD_DIV;
          end
        end
      end
      RD_DIV: begin
        rem_nxt  = rem_ge ? (rem_sh - {1'b0, cnt_r}) : rem_sh;
        quo_nxt  = {quo_r[TOTAL_W-2:0], rem_ge};
        step_nxt = step_r + 1'b1;
        if (step_r == DIV_STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = RD_DONE;
        end
      end
      RD_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = RD_IDLE;
        end
      end
      default: state_nxt = RD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= RD_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    if (state_r == RD_IDLE && req_valid) begin
      cell_r <= req.cell_idx;
      cnt_r  <= req.count;
      tot_r  <= req.total;
      pres_r <= req.presence;
      neg_r  <= req.total[TOTAL_W-1];
    end
    if (load_out) begin
      out_data_r <= {4'd0, npres, pres_r, mean, tot_r, cnt_r, cell_r};
    end
  end

  // A new snapshot may only arrive while the unit is free.
  a_req_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid |-> (state_r == RD_IDLE))
    else $error("read-out request while divider busy");

  // The partial remainder stays below the divisor throughout the division.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == RD_DIV) |-> (rem_r < {1'b0, cnt_r}))
    else $error("divider remainder out of range");

  // After its last step the divider moves on to RD_DONE.
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == RD_DIV && step_r == DIV_STEP_W'(DIV_STEPS - 1)) |=> (state_r == RD_DONE))
    else $error("divider did not finish on its last step");

endmodule

// File: rtl/cell_histogram_binner.sv
// Top level of the cell histogram binner: configuration registers, the
// clearing sweep, the read-modify-write stage over the cell store and the
// read-out unit. Depends on chb_pkg, chb_ram and chb_readout.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   in_     | input     | in_tvalid/in_tready   | tdata 56 b, tuser 1 b (action)
//   out_    | output    | out_tvalid/out_tready | tdata 136 b, at most one result per read
//   cfg_    | input     | cfg_valid/cfg_ready   | cfg_index 2 b, cfg_data 1 b
//
// The store word of a bin is read at acceptance and written back the next
// cycle, with the last write forwarded, so bins stream one per cycle while
// in_tready is high. A read passes through the bit-serial divider (48 steps)
// that forms the mean; an empty cell skips the division. After reset a
// clearing pass writes zeros to every one of the DEPTH cells (65536 by
// default), one per cycle, while in_tready stays low.
// A stalled output holds the divider's result and then new reads.
module cell_histogram_binner #(
  parameter int CELLS   = 65536,
  parameter int CLASSES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // cell_req [15:0], value [47:16], class_id [50:48], zero [55:51]
  input  logic [chb_pkg::IN_DATA_W-1:0]     in_tdata,
  // action [0]
  input  logic [chb_pkg::IN_USER_W-1:0]     in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // cell_out [15:0], count [39:16], total [87:40], mean [119:88],
  // presence [127:120], classes_present [131:128], zero [135:132]
  output logic [chb_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [chb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic                              cfg_data
);

  import chb_pkg::*;

  localparam int DEPTH = (CELLS < 65536) ? CELLS : 65536;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Input fields.
  logic                      in_action;
  logic [CELL_W-1:0]         in_cell_req;
  logic [VALUE_W-1:0]        in_value;
  logic [CLASS_W-1:0]        in_class_id;
  logic                      in_acc;
  logic                      in_range;

  // Configuration.
  logic emit_all_r, use_values_r, track_pres_r;

  // Clearing sweep.
  logic          clearing_r, clearing_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  // Modify stage.
  logic                 s1_valid_r;
  logic                 s1_read_r;
  logic [AW-1:0]        s1_addr_r;
  logic [CELL_W-1:0]    s1_cell_r;
  logic [VALUE_W-1:0]   s1_value_r;
  logic [CLASS_W-1:0]   s1_class_r;

  // Forwarding of the last write.
  logic                 fw_valid_r;
  logic [AW-1:0]        fw_addr_r;
  logic [WORD_W-1:0]    fw_data_r;

  // Store access.
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic [WORD_W-1:0]    ram_rdata;

  logic [WORD_W-1:0]    cur_word;
  logic [COUNT_W-1:0]   cur_cnt, new_cnt;
  logic [TOTAL_W-1:0]   cur_tot, new_tot;
  logic [PRES_W-1:0]    cur_pres, new_pres;
  logic [TOTAL_W:0]     sum;
  logic                 bin_wr;

  rd_req_t              rd_req;
  logic                 rd_req_valid;
  logic                 rd_busy;

  assign in_cell_req = in_tdata[CELL_W-1:0];
  assign in_value    = in_tdata[CELL_W +: VALUE_W];
  assign in_class_id = in_tdata[CELL_W+VALUE_W +: CLASS_W];
  assign in_action   = in_tuser[0];

  assign in_tready = !clearing_r && !rd_busy && !(s1_valid_r && s1_read_r);
  assign in_acc    = in_tvalid && in_tready;
  assign in_range  = (32'(in_cell_req) < CELLS);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_all_r   <= 1'b1;
      use_values_r <= 1'b0;
      track_pres_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_EMIT_ALL:  emit_all_r   <= cfg_data;
        CFG_USE_VALS:  use_values_r <= cfg_data;
        CFG_TRACK_PRS: track_pres_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  // The write-back of the previous item lands on the same edge as this
  // item's read, so the read data can be one write stale.
  assign cur_word = (fw_valid_r && fw_addr_r == s1_addr_r) ? fw_data_r : ram_rdata;
  assign cur_cnt  = cur_word[CNT_LSB +: COUNT_W];
  assign cur_tot  = cur_word[TOT_LSB +: TOTAL_W];
  assign cur_pres = cur_word[PRES_LSB +: PRES_W];

  assign sum = {cur_tot[TOTAL_W-1], cur_tot}
             + {{(TOTAL_W+1-VALUE_W){s1_value_r[VALUE_W-1]}}, s1_value_r};

  always_comb begin
    new_cnt = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
    new_tot = cur_tot;
    if (use_values_r) begin
      if (sum[TOTAL_W] != sum[TOTAL_W-1]) begin
        new_tot = sum[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX;
      end else begin
        new_tot = sum[TOTAL_W-1:0];
      end
    end
    new_pres = cur_pres;
    if (track_pres_r && (32'(s1_class_r) < CLASSES)) begin
      new_pres = cur_pres | (PRES_W'(1) << s1_class_r);
    end
  end

  assign bin_wr = s1_valid_r && !s1_read_r;

  always_comb begin
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = bin_wr;
      ram_waddr = s1_addr_r;
      ram_wdata = {new_pres, new_tot, new_cnt};
    end
  end

  chb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc && in_range),
    .raddr (in_cell_req[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_req.cell_idx = s1_cell_r;
  assign rd_req.count    = cur_cnt;
  assign rd_req.total    = cur_tot;
  assign rd_req.presence = cur_pres;
  assign rd_req_valid    = s1_valid_r && s1_read_r && !(cur_cnt == '0 && !emit_all_r);

  chb_readout u_readout (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (rd_req_valid),
    .req        (rd_req),
    .busy       (rd_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
      s1_valid_r <= 1'b0;
      fw_valid_r <= 1'b0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_addr_r <= clr_addr_nxt;
      s1_valid_r <= in_acc && in_range;
      if (bin_wr) begin
        fw_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_read_r  <= (in_action == ACT_READ);
      s1_addr_r  <= in_cell_req[AW-1:0];
      s1_cell_r  <= in_cell_req;
      s1_value_r <= in_value;
      s1_class_r <= in_class_id;
    end
    if (bin_wr) begin
      fw_addr_r <= s1_addr_r;
      fw_data_r <= ram_wdata;
    end
  end

  // Nothing may enter the store while it is still being cleared.
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_tready)
    else $error("input accepted during clearing pass");

  // A read reaching the modify stage must find the divider free.
  a_read_finds_free: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_read_r) |-> !rd_busy)
    else $error("read snapshot while read-out unit busy");

  // An accepted in-range bin is written back on the next cycle.
  a_bin_written: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_range && in_action == ACT_BIN) |=> (ram_we && !clearing_r))
    else $error("bin transaction not written back");

  // The forwarded word always follows a completed bin write.
  a_fw_after_bin: assert property (@(posedge clk) disable iff (!rst_n)
    bin_wr |=> (fw_valid_r && fw_addr_r == $past(s1_addr_r)))
    else $error("forwarding register missed a write");

endmodule

// File: dv/cell_histogram_binner_test.sv
// Self-checking testbench for cell_histogram_binner: streams bin and read
// transactions, predicts every read-out and compares it field by field.
// Depends on chb_pkg and the cell_histogram_binner RTL.

class cell_tally_board;
  typedef struct {
    logic [15:0] cell_idx;
    logic [23:0] count;
    logic [47:0] total;
    logic [31:0] mean;
    logic [7:0]  presence;
    logic [3:0]  classes;
  } readout_t;

  bit emit_all = 1'b1;
  bit use_vals = 1'b0;
  bit track_prs = 1'b0;
  int unsigned failures = 0;

  int     tally_count [int];
  longint tally_total [int];
  bit [7:0] tally_pres [int];
  readout_t readouts_due [$];

  function void set_reg(logic [chb_pkg::CFG_IDX_W-1:0] idx, logic d);
    case (idx)
      chb_pkg::CFG_EMIT_ALL:  emit_all = d;
      chb_pkg::CFG_USE_VALS:  use_vals = d;
      chb_pkg::CFG_TRACK_PRS: track_prs = d;
      default: ;
    endcase
  endfunction

  function int pending();
    return readouts_due.size();
  endfunction

  // Updates the mirrored cell store for a bin, or queues the read-out that a
  // read transaction should produce.
  function void note_input(logic act, logic [chb_pkg::IN_DATA_W-1:0] data);
    int c;
    longint v;
    longint sum;
    longint q;
    readout_t r;
    c = int'(data[15:0]);
    v = longint'($signed(data[47:16]));
    if (!tally_count.exists(c)) begin
      tally_count[c] = 0;
      tally_total[c] = 0;
      tally_pres[c] = '0;
    end
    if (act == chb_pkg::ACT_BIN) begin
      if (tally_count[c] < 24'hFFFFFF) tally_count[c]++;
      if (use_vals) begin
        sum = tally_total[c] + v;
        if (sum > 64'sd140737488355327) sum = 64'sd140737488355327;
        if (sum < -64'sd140737488355328) sum = -64'sd140737488355328;
        tally_total[c] = sum;
      end
      if (track_prs) tally_pres[c][data[50:48]] = 1'b1;
      return;
    end
    if (tally_count[c] == 0 && !emit_all) return;
    q = 0;
    if (tally_count[c] != 0) begin
      // SystemVerilog signed division truncates toward zero, as the block does.
      q = tally_total[c] / longint'(tally_count[c]);
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
    end
    r.cell_idx = data[15:0];
    r.count = tally_count[c][23:0];
    r.total = tally_total[c][47:0];
    r.mean = q[31:0];
    r.presence = tally_pres[c];
    r.classes = 4'($countones(tally_pres[c]));
    readouts_due = {readouts_due, r};
  endfunction

  function void compare_field(string fname, logic [15:0] cell_idx, logic [63:0] want,
                              logic [63:0] got);
    if (want !== got) begin
      failures++;
      if (failures <= 10)
        $display("cell %0d %s mismatch: expected 0x%0h, got 0x%0h", cell_idx, fname,
                 want, got);
    end
  endfunction

  function void check_result(logic [chb_pkg::OUT_DATA_W-1:0] d);
    readout_t r;
    if (readouts_due.size() == 0) begin
      failures++;
      if (failures <= 10) $display("unexpected read-out for cell %0d", d[15:0]);
      return;
    end
    r = readouts_due.pop_front();
    compare_field("cell", r.cell_idx, r.cell_idx, d[15:0]);
    compare_field("count", r.cell_idx, r.count, d[39:16]);
    compare_field("total", r.cell_idx, r.total, d[87:40]);
    compare_field("mean", r.cell_idx, r.mean, d[119:88]);
    compare_field("presence", r.cell_idx, r.presence, d[127:120]);
    compare_field("classes_present", r.cell_idx, r.classes, d[131:128]);
  endfunction
endclass

module cell_histogram_binner_test;
  timeunit 1ns;
  timeprecision 1ps;

  import chb_pkg::*;

  // The clearing pass after reset alone keeps the input closed until every cell is cleared.
  localparam int unsigned STUCK_LIMIT = 250000;
  localparam int SETTLE = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [IN_USER_W-1:0] in_tuser = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic cfg_data = 1'b0;

  bit idle_on = 1'b1;
  int stall_left = 0;
  int unsigned stuck_cycles = 0;
  logic [15:0] hot_cells [24];
  cell_tally_board board = new();

  cell_histogram_binner DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Result side back-pressure in short random bursts.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.set_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) board.note_input(in_tuser[0], in_tdata);
      if (out_tvalid && out_tready) board.check_result(out_tdata);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("no transaction for %0d cycles", STUCK_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(logic act, logic [15:0] cell_idx, logic [31:0] val,
                           logic [2:0] cls);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tuser <= act;
    in_tdata <= {5'b0, cls, val, cell_idx};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Leaves cfg_valid high so that writes can follow back to back; the caller
  // drops it after the last one.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic d);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Waits until every queued read-out has arrived and the block has gone quiet;
  // a read of an empty cell may still be in flight without a result.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(logic emit, logic vals, logic track);
    drain_results();
    write_reg(CFG_EMIT_ALL, emit);
    write_reg(CFG_USE_VALS, vals);
    write_reg(CFG_TRACK_PRS, track);
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_items();
    set_config(1'b1, 1'b1, 1'b1);
    send_item(ACT_READ, 16'h0000, 32'h0, 3'd0);
    send_item(ACT_BIN, 16'h0000, 32'h7FFFFFFF, 3'd7);
    send_item(ACT_BIN, 16'h0000, 32'h80000000, 3'd0);
    send_item(ACT_BIN, 16'hFFFF, 32'hFFFFFFFF, 3'd5);
    send_item(ACT_BIN, 16'hFFFF, 32'h00010000, 3'd2);
    send_item(ACT_READ, 16'h0000, 32'h0, 3'd0);
    send_item(ACT_READ, 16'hFFFF, 32'hFFFFFFFF, 3'd7);
    send_item(ACT_BIN, 16'h5555, 32'h55555555, 3'd1);
    send_item(ACT_BIN, 16'hAAAA, 32'hAAAAAAAA, 3'd6);
    send_item(ACT_READ, 16'h5555, 32'h0, 3'd0);
    send_item(ACT_READ, 16'hAAAA, 32'h0, 3'd0);
    // Negative mean with a remainder checks truncation toward zero.
    send_item(ACT_BIN, 16'h0003, 32'hFFFFFFF9, 3'd3);
    send_item(ACT_BIN, 16'h0003, 32'h00000002, 3'd4);
    send_item(ACT_READ, 16'h0003, 32'h0, 3'd0);
    // With empty cells suppressed an unused cell gives nothing.
    set_config(1'b0, 1'b1, 1'b1);
    send_item(ACT_READ, 16'h1234, 32'h0, 3'd0);
    send_item(ACT_READ, 16'h0000, 32'h0, 3'd0);
    // Values and classes are ignored now; earlier presence bits stay reported.
    set_config(1'b0, 1'b0, 1'b0);
    send_item(ACT_BIN, 16'h0000, 32'h00050000, 3'd6);
    send_item(ACT_READ, 16'h0000, 32'h0, 3'd0);
    send_item(ACT_BIN, 16'h4321, 32'h12345678, 3'd3);
    send_item(ACT_READ, 16'h4321, 32'h0, 3'd0);
  endtask

  task automatic random_items(int n);
    logic act;
    logic [15:0] cell_sel;
    logic [31:0] val;
    int pick;
    repeat (n) begin
      act = ($urandom_range(0, 99) < 35) ? ACT_READ : ACT_BIN;
      cell_sel = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                             : hot_cells[$urandom_range(0, 23)];
      pick = $urandom_range(0, 9);
      if (pick == 0) val = 32'h7FFFFFFF;
      else if (pick == 1) val = 32'h80000000;
      else if (pick < 5) val = 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      else val = $urandom;
      send_item(act, cell_sel, val, 3'($urandom_range(0, 7)));
    end
  endtask

  initial begin
    hot_cells[0] = 16'h0000;
    hot_cells[1] = 16'hFFFF;
    for (int i = 2; i < 24; i++) hot_cells[i] = 16'($urandom_range(0, 65535));
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    directed_items();
    set_config(1'b1, 1'b1, 1'b1);
    random_items(330);
    set_config(1'b0, 1'b1, 1'b1);
    random_items(320);
    set_config(1'b1, 1'b0, 1'b0);
    random_items(320);
    set_config(1'b0, 1'b0, 1'b1);
    random_items(320);
    set_config(1'b1, 1'b1, 1'b0);
    random_items(320);
    set_config(1'b1, 1'b1, 1'b1);
    idle_on = 1'b0;
    random_items(320);
    drain_results();
    if (board.pending() != 0) $display("%0d read-outs never arrived", board.pending());
    if (board.failures == 0 && board.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
